FILE: hdl/rsvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsvd_pkg;

  localparam int ROI_PIXELS  = 16384;
  localparam int MAP_AW      = $clog2(ROI_PIXELS);
  localparam int CLR_W       = MAP_AW + 1;
  localparam int CNT_W       = 15;
  localparam int SUM_W       = 22;
  localparam int GREY_W      = 8;
  localparam int FLEN_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int DIVR_W      = CNT_W + 1;
  localparam int REM_W       = DIVR_W + 1;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [GREY_W-1:0] GREY_MAX = {GREY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_TH = 2'd0,
    CFG_EDGE_TH = 2'd1,
    CFG_DARK_TH = 2'd2,
    CFG_FLEN    = 2'd3
  } cfg_index_t;

  typedef enum logic {
    KIND_ACCUM = 1'b0,
    KIND_MARK  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    kind_t              kind;
    logic               inside_roi;
    logic [MAP_AW-1:0]  map_index;
    logic               moving;
    logic               edge_req;
    logic [GREY_W-1:0]  grey;
    logic               last_pixel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_head_t;

  typedef struct packed {
    logic [CNT_W-1:0]  movement_threshold;
    logic [CNT_W-1:0]  edge_threshold;
    logic [CNT_W-1:0]  dark_threshold;
    logic [FLEN_W-1:0] filter_length;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  // saturating up/down counter clamped to 0..flen
  function automatic logic [FLEN_W-1:0] smooth_next(input logic [FLEN_W-1:0] ctr,
                                                    input logic hit,
                                                    input logic [FLEN_W-1:0] flen);
    logic [FLEN_W:0] c;
    c = {1'b0, ctr};
    if (hit) begin
      c = c + 1'b1;
    end else if (c != '0) begin
      c = c - 1'b1;
    end
    if (c > {1'b0, flen}) begin
      c = {1'b0, flen};
    end
    return c[FLEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rsvd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsvd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rsvd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rsvd_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         ack,
  input  wire logic [rsvd_pkg::SUM_W-1:0]   dividend,
  input  wire logic [rsvd_pkg::DIVR_W-1:0]  divisor,
  output logic                              busy,
  output logic                              done,
  output logic      [rsvd_pkg::SUM_W-1:0]   quotient
);

  import rsvd_pkg::*;

  div_state_t        state;
  div_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [DIVR_W-1:0] dvsr;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  diff;
  logic              last_step;
  logic              step_en;

  assign last_step = (step == STEP_W'(DIV_STEPS - 1));
  assign rem_shift = {rem[REM_W-2:0], quotient[SUM_W-1]};
  assign diff      = rem_shift - {1'b0, dvsr};

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_DONE;
      DIV_DONE: if (ack) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != DIV_IDLE);
    done    = (state == DIV_DONE);
    step_en = (state == DIV_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      quotient <= dividend;
      dvsr     <= divisor;
      rem      <= '0;
      step     <= '0;
    end else if (step_en) begin
      step <= step + 1'b1;
      if (!diff[REM_W-1]) begin
        rem      <= diff;
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift;
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rsvd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rsvd_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         req_type,
  input  wire logic                         inside_roi,
  input  wire logic [rsvd_pkg::MAP_AW-1:0]  map_index,
  input  wire logic                         moving,
  input  wire logic                         edge_req,
  input  wire logic [rsvd_pkg::GREY_W-1:0]  grey,
  input  wire logic                         last_pixel,
  input  wire logic                         clearing,
  input  wire logic                         deq,
  output rsvd_pkg::fq_head_t                head
);

  import rsvd_pkg::*;

  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              in_acc;
  logic              keep;
  logic              enq;
  item_t             new_item;

  assign full   = (count == (QPTR_W + 1)'(QUEUE_DEPTH)) || clearing;
  assign in_acc = push && !full;

  // pixels outside the region do nothing unless they close a frame
  assign keep = req_type ? inside_roi : (inside_roi || last_pixel);
  assign enq  = in_acc && keep;

  always_comb begin
    new_item.kind       = req_type ? KIND_MARK : KIND_ACCUM;
    new_item.inside_roi = inside_roi;
    new_item.map_index  = map_index;
    new_item.moving     = moving;
    new_item.edge_req   = edge_req;
    new_item.grey       = grey;
    new_item.last_pixel = last_pixel;
  end

  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rsvd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rsvd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rsvd_pkg::fq_head_t          head,
  input  wire rsvd_pkg::cfg_t              cfg,
  output logic                             deq,
  output logic                             clearing,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             stopped_vehicle,
  output logic                             motion_flag,
  output logic                             edge_flag,
  output logic                             dark_flag,
  output logic      [rsvd_pkg::GREY_W-1:0] mean_grey,
  output logic      [rsvd_pkg::CNT_W-1:0]  motion_total,
  output logic      [rsvd_pkg::CNT_W-1:0]  edge_total,
  output logic      [rsvd_pkg::CNT_W-1:0]  dark_total
);

  import rsvd_pkg::*;

  logic [CLR_W-1:0]  clr_cnt;
  logic              stall_a;
  logic              is_mark;
  logic              mark_bit;
  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_re;
  logic              ram_rdata;

  logic              b_valid;
  logic              b_inside;
  logic              b_moving;
  logic              b_edge;
  logic [GREY_W-1:0] b_grey;
  logic              b_last;

  logic [CNT_W-1:0]  motion_accum, motion_accum_next;
  logic [CNT_W-1:0]  edge_accum, edge_accum_next;
  logic [CNT_W-1:0]  dark_accum, dark_accum_next;
  logic [SUM_W-1:0]  grey_sum, grey_sum_next;
  logic [CNT_W-1:0]  pixel_total, pixel_total_next;
  logic [SUM_W:0]    sum_wide;

  logic [CNT_W-1:0]  tot_motion;
  logic [CNT_W-1:0]  tot_edge;
  logic [CNT_W-1:0]  tot_dark;
  logic [GREY_W-1:0] mean_level, mean_level_next;
  logic [FLEN_W-1:0] motion_smoother, motion_smoother_next;
  logic [FLEN_W-1:0] edge_smoother, edge_smoother_next;
  logic [FLEN_W-1:0] dark_smoother, dark_smoother_next;
  logic [FLEN_W-1:0] half_len;
  logic              mf, ef, df;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic              fin;
  logic              out_valid;
  logic [SUM_W-1:0]  quotient;
  logic [DIVR_W-1:0] divisor;

  // dark map clearing pass after reset
  assign clearing = (clr_cnt != CLR_W'(ROI_PIXELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // stage a: map access
  assign stall_a  = clearing || div_busy || (b_valid && b_last);
  assign deq      = head.valid && !stall_a;
  assign is_mark  = (head.item.kind == KIND_MARK);
  assign mark_bit = ({1'b0, head.item.grey, 1'b0} < {2'b00, mean_level});

  assign ram_we    = clearing || (deq && is_mark);
  assign ram_waddr = clearing ? clr_cnt[MAP_AW-1:0] : head.item.map_index;
  assign ram_wdata = clearing ? 1'b0 : mark_bit;
  assign ram_re    = deq && !is_mark;

  rsvd_ram #(
    .WIDTH (1),
    .DEPTH (ROI_PIXELS)
  ) u_dark_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head.item.map_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      b_inside <= head.item.inside_roi;
      b_moving <= head.item.moving;
      b_edge   <= head.item.edge_req;
      b_grey   <= head.item.grey;
      b_last   <= head.item.last_pixel;
    end
  end

  // stage b: accumulate
  assign sum_wide = {1'b0, grey_sum} + {{(SUM_W + 1 - GREY_W){1'b0}}, b_grey};

  always_comb begin
    motion_accum_next = motion_accum;
    edge_accum_next   = edge_accum;
    dark_accum_next   = dark_accum;
    grey_sum_next     = grey_sum;
    pixel_total_next  = pixel_total;
    if (b_inside) begin
      if (b_moving) motion_accum_next = sat_inc(motion_accum);
      if (b_edge)   edge_accum_next   = sat_inc(edge_accum);
      if (ram_rdata) dark_accum_next  = sat_inc(dark_accum);
      grey_sum_next    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      pixel_total_next = sat_inc(pixel_total);
    end
  end

  assign div_start = b_valid && b_last;
  assign divisor   = {1'b0, pixel_total_next} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_accum <= '0;
      edge_accum   <= '0;
      dark_accum   <= '0;
      grey_sum     <= '0;
      pixel_total  <= '0;
    end else if (b_valid) begin
      if (b_last) begin
        motion_accum <= '0;
        edge_accum   <= '0;
        dark_accum   <= '0;
        grey_sum     <= '0;
        pixel_total  <= '0;
      end else begin
        motion_accum <= motion_accum_next;
        edge_accum   <= edge_accum_next;
        dark_accum   <= dark_accum_next;
        grey_sum     <= grey_sum_next;
        pixel_total  <= pixel_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      tot_motion <= motion_accum_next;
      tot_edge   <= edge_accum_next;
      tot_dark   <= dark_accum_next;
    end
  end

  rsvd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .ack      (fin),
    .dividend (grey_sum_next),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // frame close: mean, smoothing, result register
  assign fin      = div_done && (!out_valid || pop);
  assign half_len = cfg.filter_length >> 1;

  always_comb begin
    mean_level_next      = (quotient[SUM_W-1:GREY_W] != '0) ? GREY_MAX
                                                             : quotient[GREY_W-1:0];
    motion_smoother_next = smooth_next(motion_smoother,
                                       tot_motion > cfg.movement_threshold,
                                       cfg.filter_length);
    edge_smoother_next   = smooth_next(edge_smoother,
                                       tot_edge > cfg.edge_threshold,
                                       cfg.filter_length);
    dark_smoother_next   = smooth_next(dark_smoother,
                                       tot_dark > cfg.dark_threshold,
                                       cfg.filter_length);
    mf = motion_smoother_next > half_len;
    ef = edge_smoother_next > half_len;
    df = dark_smoother_next > half_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_level      <= '0;
      motion_smoother <= '0;
      edge_smoother   <= '0;
      dark_smoother   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (fin) begin
        mean_level      <= mean_level_next;
        motion_smoother <= motion_smoother_next;
        edge_smoother   <= edge_smoother_next;
        dark_smoother   <= dark_smoother_next;
        out_valid       <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      stopped_vehicle <= !mf && ef && df;
      motion_flag     <= mf;
      edge_flag       <= ef;
      dark_flag       <= df;
      mean_grey       <= mean_level_next;
      motion_total    <= tot_motion;
      edge_total      <= tot_edge;
      dark_total      <= tot_dark;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: hdl/roi_stopped_vehicle_detector_core.sv
// stopped vehicle detector for one region of interest
//
// input queue: present a pixel with push while full is low; one transfer per
// clock. req_type 0 pixels form the analysis pass, req_type 1 pixels rewrite
// the dark map from the last computed mean grey.
// result queue: one result per analysis pass, after the pixel marked
// last_pixel; it stays on the result ports while empty is low and leaves on
// pop. config port: cfg_index/cfg_data, transfer on cfg_valid && cfg_ready;
// cfg_ready is always high. write only while the block is idle.
// throughput: one pixel per clock within a pass. after the last analysis
// pixel the back end pauses while the mean division runs at one quotient
// bit per cycle; a four-entry queue absorbs the first pixels of that gap.
// from the last pixel, the result passes stage b, the divider and the result register to the ports.
// reset: thresholds 0/0/100, filter length 5, counters cleared; then the
// 16384-entry dark map is cleared one entry per cycle with full held high.
// if the result is not popped, the next frame close waits, pixels keep
// flowing into the queue until it fills, then full rises.
`timescale 1ns / 1ps
`default_nettype none

module roi_stopped_vehicle_detector_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              req_type,
  input  wire logic                              inside_roi,
  input  wire logic [rsvd_pkg::MAP_AW-1:0]       map_index,
  input  wire logic                              moving,
  input  wire logic                              edge_req,
  input  wire logic [rsvd_pkg::GREY_W-1:0]       grey,
  input  wire logic                              last_pixel,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   stopped_vehicle,
  output logic                                   motion_flag,
  output logic                                   edge_flag,
  output logic                                   dark_flag,
  output logic      [rsvd_pkg::GREY_W-1:0]       mean_grey,
  output logic      [rsvd_pkg::CNT_W-1:0]        motion_total,
  output logic      [rsvd_pkg::CNT_W-1:0]        edge_total,
  output logic      [rsvd_pkg::CNT_W-1:0]        dark_total,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rsvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsvd_pkg::CNT_W-1:0]        cfg_data
);

  import rsvd_pkg::*;

  cfg_t     cfg;
  fq_head_t head;
  logic     deq;
  logic     clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.movement_threshold <= '0;
      cfg.edge_threshold     <= '0;
      cfg.dark_threshold     <= CNT_W'(100);
      cfg.filter_length      <= FLEN_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_MOVE_TH: cfg.movement_threshold <= cfg_data;
        CFG_EDGE_TH: cfg.edge_threshold     <= cfg_data;
        CFG_DARK_TH: cfg.dark_threshold     <= cfg_data;
        CFG_FLEN:    cfg.filter_length      <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  rsvd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .inside_roi (inside_roi),
    .map_index  (map_index),
    .moving     (moving),
    .edge_req   (edge_req),
    .grey       (grey),
    .last_pixel (last_pixel),
    .clearing   (clearing),
    .deq        (deq),
    .head       (head)
  );

  rsvd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .cfg             (cfg),
    .deq             (deq),
    .clearing        (clearing),
    .empty           (empty),
    .pop             (pop),
    .stopped_vehicle (stopped_vehicle),
    .motion_flag     (motion_flag),
    .edge_flag       (edge_flag),
    .dark_flag       (dark_flag),
    .mean_grey       (mean_grey),
    .motion_total    (motion_total),
    .edge_total      (edge_total),
    .dark_total      (dark_total)
  );

endmodule

`default_nettype wire
